/* rtl/prca_pkg.sv */
// Shared types, codes and constants of the peer registry block.
`default_nettype none

package prca_pkg;

   // Table size and result limits.
   localparam int TABLE_ENTRIES_DEFAULT = 64;
   localparam int MAX_RESULTS           = 64;
   localparam int LIST_CNT_W            = 7;

   // Configuration register defaults (live timeout is five minutes).
   localparam logic [15:0] LIVE_TIMEOUT_RESET      = 16'd300;
   localparam logic [7:0]  CHALLENGE_TIMEOUT_RESET = 8'd2;

   // Heartbeat port window, both bounds exclusive.
   localparam logic [15:0] PORT_MIN_EXCL = 16'd1024;
   localparam logic [15:0] PORT_MAX_EXCL = 16'd65535;

   // Stream and register port widths.
   localparam int REQ_TDATA_W = 128;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_TUSER_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_LIVE_TIMEOUT      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHALLENGE_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      ACT_HEARTBEAT  = 2'd0,
      ACT_ECHO_REPLY = 2'd1,
      ACT_LIST_QUERY = 2'd2,
      ACT_UNUSED     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_FREE     = 2'd0,
      ST_PENDING  = 2'd1,
      ST_VERIFIED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      KIND_ACK        = 3'd0,
      KIND_REJECTED   = 3'd1,
      KIND_LIST_ENTRY = 3'd2,
      KIND_EMPTY_LIST = 3'd3,
      KIND_VERIFIED   = 3'd4,
      KIND_FAILED     = 3'd5,
      KIND_UNMATCHED  = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      FSM_CLEAR  = 2'd0,
      FSM_IDLE   = 2'd1,
      FSM_SCAN   = 2'd2,
      FSM_FINISH = 2'd3
   } fsm_type;

   // One row of the peer data memory.
   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] port;
      logic [15:0] protocol;
      logic [31:0] stamp;
      logic [13:0] key;
   } entry_type;

   // One result beat before packing onto the response stream.
   typedef struct packed {
      kind_type    kind;
      logic        challenge;
      logic [5:0]  slot;
      logic [31:0] addr;
      logic [15:0] port;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

/* rtl/peer_registry_with_challenge_aging.sv */
// Top level of the peer registry: request sequencer, table scan and result stage.
`default_nettype none

// A scanned request reads every table entry once, one table read per entry, and then loads its
//   final result into the output register; a new request is taken only while idle.
// A rejected heartbeat or an unused action skips the scan and goes straight to the final
//   result. A held-off response side stalls both.
// Reset: synchronous; a clearing pass then frees every status entry while req_tready stays
//   low. Timeouts return to 300 and 2 seconds.
module peer_registry_with_challenge_aging #(
   parameter int TABLE_ENTRIES = prca_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request stream.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // now_seconds[31:0], peer_addr[63:32], peer_port[79:64], peer_protocol[95:80],
   // offered_key[109:96], reply_key[123:110], zero fill[127:124]
   input  wire logic [prca_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // action[1:0]
   input  wire logic [prca_pkg::REQ_TUSER_W-1:0]     req_tuser,
   // Response stream.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // entry_slot[5:0], entry_addr[37:6], entry_port[53:38], zero fill[55:54]
   output logic [prca_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   // reply_kind[2:0], send_challenge[3]
   output logic [prca_pkg::RSP_TUSER_W-1:0]          rsp_tuser,
   output logic                                      rsp_tlast,
   // Configuration write port.
   input  wire logic                                 csr_we,
   input  wire logic [prca_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [prca_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(TABLE_ENTRIES);
   localparam logic [prca_pkg::LIST_CNT_W-1:0] LIST_LIMIT =
      prca_pkg::LIST_CNT_W'(prca_pkg::MAX_RESULTS);

   // ------------------------------------------------------------------
   // Sequencer state and configuration registers.
   // ------------------------------------------------------------------
   prca_pkg::fsm_type state_ff, state_in;
   logic [15:0] live_timeout_ff;
   logic [7:0]  chal_timeout_ff;

   // Request registers, captured when the request beat is accepted.
   prca_pkg::action_type act_ff;
   logic        reject_ff;
   logic [31:0] now_ff;
   logic [31:0] addr_ff;
   logic [15:0] port_ff;
   logic [15:0] proto_ff;
   logic [13:0] offered_ff;
   logic [13:0] rkey_ff;

   // Scan control. cnt_ff also sweeps the status memory after reset.
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0] s1_idx_ff;

   // Scan findings.
   logic                               have_free_ff, have_free_in;
   logic                               hit_ff, hit_in;
   logic [IDX_W-1:0]                   cand_ff, cand_in;
   logic [5:0]                         res_slot_ff, res_slot_in;
   prca_pkg::kind_type                 res_kind_ff, res_kind_in;
   logic [prca_pkg::LIST_CNT_W-1:0]    list_cnt_ff, list_cnt_in;

   // Result stage: a holding register keeps the newest list beat so that its last
   // flag can be decided once the scan knows whether another verified entry follows.
   logic                  hold_valid_ff;
   prca_pkg::result_type  hold_ff;
   logic                  rsp_valid_ff;
   prca_pkg::result_type  rsp_ff;

   // ------------------------------------------------------------------
   // Request decode.
   // ------------------------------------------------------------------
   prca_pkg::action_type req_action;
   logic [15:0] req_port;
   logic [15:0] req_proto;
   logic        req_accept;
   logic        req_reject;

   assign req_action = prca_pkg::action_type'(req_tuser);
   assign req_port   = req_tdata[79:64];
   assign req_proto  = req_tdata[95:80];
   assign req_accept = req_tvalid && req_tready;

   // A heartbeat needs a port strictly inside the window and a nonzero protocol.
   assign req_reject = (req_action == prca_pkg::ACT_UNUSED) ||
                       ((req_action == prca_pkg::ACT_HEARTBEAT) &&
                        !((req_port > prca_pkg::PORT_MIN_EXCL) &&
                          (req_port != prca_pkg::PORT_MAX_EXCL) &&
                          (req_proto != 16'd0)));

   // ------------------------------------------------------------------
   // Table memories.
   // ------------------------------------------------------------------
   logic                 tbl_rd_en;
   logic [IDX_W-1:0]     tbl_rd_idx;
   prca_pkg::status_type rd_status;
   prca_pkg::entry_type  rd_entry;
   logic [IDX_W-1:0]     tbl_wr_idx;
   logic                 st_we;
   prca_pkg::status_type st_wd;
   logic                 ent_we;
   prca_pkg::entry_type  ent_wd;

   prca_table #(
      .ENTRIES (TABLE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock        (clock),
      .rd_en        (tbl_rd_en),
      .rd_idx       (tbl_rd_idx),
      .rd_status_ff (rd_status),
      .rd_entry_ff  (rd_entry),
      .wr_idx       (tbl_wr_idx),
      .status_we    (st_we),
      .status_wd    (st_wd),
      .entry_we     (ent_we),
      .entry_wd     (ent_wd)
   );

   // ------------------------------------------------------------------
   // State machine.
   // ------------------------------------------------------------------
   logic clearing;
   logic scanning;
   logic finishing;
   logic rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prca_pkg::FSM_CLEAR: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = prca_pkg::FSM_IDLE;
            end
         end
         prca_pkg::FSM_IDLE: begin
            if (req_accept) begin
               state_in = req_reject ? prca_pkg::FSM_FINISH : prca_pkg::FSM_SCAN;
            end
         end
         prca_pkg::FSM_SCAN: begin
            // All reads issued and the last entry written back.
            if ((cnt_ff == END_CNT) && !s1_valid_ff) begin
               state_in = prca_pkg::FSM_FINISH;
            end
         end
         prca_pkg::FSM_FINISH: begin
            if (rsp_free) begin
               state_in = prca_pkg::FSM_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      clearing   = 1'b0;
      scanning   = 1'b0;
      finishing  = 1'b0;
      unique case (state_ff)
         prca_pkg::FSM_CLEAR:  clearing   = 1'b1;
         prca_pkg::FSM_IDLE:   req_tready = 1'b1;
         prca_pkg::FSM_SCAN:   scanning   = 1'b1;
         prca_pkg::FSM_FINISH: finishing  = 1'b1;
      endcase
   end

   // ------------------------------------------------------------------
   // Entry evaluation on the read data of the entry in the second stage.
   // Each entry is read exactly once per scan and written at most once; the next
   // read is always a different entry, so no forwarding is needed; the candidate
   // write at the end of a heartbeat lands before the next request's first read.
   // ------------------------------------------------------------------
   logic [31:0] age;
   logic [31:0] timeout;
   logic        live;
   logic        match;
   logic        stale;
   logic        key_eq;
   logic        list_emit;
   logic        emit_ok;
   logic        advance;
   logic        proc;
   logic        issue;
   logic        fin_write;

   assign age     = now_ff - rd_entry.stamp;
   assign timeout = (act_ff == prca_pkg::ACT_ECHO_REPLY) ? {24'd0, chal_timeout_ff}
                                                         : {16'd0, live_timeout_ff};
   assign stale   = age > timeout;
   assign live    = rd_status != prca_pkg::ST_FREE;
   assign match   = (rd_entry.addr == addr_ff) && (rd_entry.port == port_ff);
   assign key_eq  = rd_entry.key == rkey_ff;

   // A verified entry that survives aging is listed, up to the result limit.
   assign list_emit = (act_ff == prca_pkg::ACT_LIST_QUERY) && s1_valid_ff &&
                      (rd_status == prca_pkg::ST_VERIFIED) && !stale &&
                      (list_cnt_ff < LIST_LIMIT);

   // The holding register can take a new beat if it is empty or can pass its
   // current beat on to the output register.
   assign emit_ok = !hold_valid_ff || rsp_free;
   assign advance = !(list_emit && !emit_ok);
   assign proc    = scanning && s1_valid_ff && advance;
   assign issue   = scanning && advance && (cnt_ff != END_CNT);

   assign tbl_rd_en  = issue;
   assign tbl_rd_idx = cnt_ff[IDX_W-1:0];

   // A heartbeat from a new peer claims the first free entry once the scan is over.
   assign fin_write = finishing && rsp_free && !reject_ff &&
                      (act_ff == prca_pkg::ACT_HEARTBEAT) && !hit_ff && have_free_ff;

   always_comb begin
      st_we        = 1'b0;
      st_wd        = prca_pkg::ST_FREE;
      ent_we       = 1'b0;
      ent_wd       = rd_entry;
      tbl_wr_idx   = s1_idx_ff;
      have_free_in = have_free_ff;
      hit_in       = hit_ff;
      cand_in      = cand_ff;
      res_slot_in  = res_slot_ff;
      res_kind_in  = res_kind_ff;
      list_cnt_in  = list_cnt_ff;

      if (req_accept) begin
         have_free_in = 1'b0;
         hit_in       = 1'b0;
         cand_in      = '0;
         res_slot_in  = '0;
         res_kind_in  = prca_pkg::KIND_UNMATCHED;
         list_cnt_in  = '0;
      end

      if (clearing) begin
         st_we      = 1'b1;
         tbl_wr_idx = cnt_ff[IDX_W-1:0];
      end else if (proc) begin
         case (act_ff)
            prca_pkg::ACT_HEARTBEAT: begin
               if (!live) begin
                  if (!have_free_ff) begin
                     have_free_in = 1'b1;
                     cand_in      = s1_idx_ff;
                  end
               end else if (match) begin
                  // Every matching live entry is refreshed; the lowest one is reported.
                  ent_we       = 1'b1;
                  ent_wd.stamp = now_ff;
                  if (!hit_ff) begin
                     hit_in      = 1'b1;
                     res_slot_in = 6'(s1_idx_ff);
                  end
               end else if (stale) begin
                  st_we = 1'b1;
               end
            end
            prca_pkg::ACT_ECHO_REPLY: begin
               if (rd_status == prca_pkg::ST_PENDING) begin
                  if (!hit_ff && match) begin
                     // The lowest matching pending entry decides; an expired one
                     // is freed even when the key is right.
                     hit_in      = 1'b1;
                     res_slot_in = 6'(s1_idx_ff);
                     st_we       = 1'b1;
                     if (!stale && key_eq) begin
                        st_wd       = prca_pkg::ST_VERIFIED;
                        res_kind_in = prca_pkg::KIND_VERIFIED;
                     end else begin
                        res_kind_in = prca_pkg::KIND_FAILED;
                     end
                  end else if (stale) begin
                     st_we = 1'b1;
                  end
               end
            end
            prca_pkg::ACT_LIST_QUERY: begin
               if (live && stale) begin
                  st_we = 1'b1;
               end
               if (list_emit) begin
                  list_cnt_in = list_cnt_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (fin_write) begin
         st_we           = 1'b1;
         st_wd           = prca_pkg::ST_PENDING;
         ent_we          = 1'b1;
         tbl_wr_idx      = cand_ff;
         ent_wd.addr     = addr_ff;
         ent_wd.port     = port_ff;
         ent_wd.protocol = proto_ff;
         ent_wd.stamp    = now_ff;
         ent_wd.key      = offered_ff;
      end
   end

   // Counter and stage-one valid.
   always_comb begin
      cnt_in      = cnt_ff;
      s1_valid_in = 1'b0;
      if (clearing) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (req_accept) begin
         cnt_in = '0;
      end else if (scanning) begin
         s1_valid_in = advance ? issue : s1_valid_ff;
         if (issue) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Results.
   // ------------------------------------------------------------------
   prca_pkg::result_type list_res;
   prca_pkg::result_type fin_res;
   logic                 load_scan;
   logic                 load_fin;

   always_comb begin
      list_res           = '0;
      list_res.kind      = prca_pkg::KIND_LIST_ENTRY;
      list_res.slot      = 6'(s1_idx_ff);
      list_res.addr      = rd_entry.addr;
      list_res.port      = rd_entry.port;
      list_res.last      = 1'b0;
   end

   // The single result of a heartbeat, echo or reject, or the closing list beat.
   always_comb begin
      fin_res      = '0;
      fin_res.last = 1'b1;
      fin_res.kind = prca_pkg::KIND_REJECTED;
      if (!reject_ff) begin
         case (act_ff)
            prca_pkg::ACT_HEARTBEAT: begin
               fin_res.kind = prca_pkg::KIND_ACK;
               if (hit_ff) begin
                  fin_res.slot = res_slot_ff;
               end else if (have_free_ff) begin
                  fin_res.challenge = 1'b1;
                  fin_res.slot      = 6'(cand_ff);
               end
            end
            prca_pkg::ACT_ECHO_REPLY: begin
               fin_res.kind = res_kind_ff;
               fin_res.slot = res_slot_ff;
            end
            prca_pkg::ACT_LIST_QUERY: begin
               if (hold_valid_ff) begin
                  fin_res      = hold_ff;
                  fin_res.last = 1'b1;
               end else begin
                  fin_res.kind = prca_pkg::KIND_EMPTY_LIST;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign load_scan = proc && list_emit && hold_valid_ff;
   assign load_fin  = finishing && rsp_free;

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= prca_pkg::FSM_CLEAR;
         live_timeout_ff <= prca_pkg::LIVE_TIMEOUT_RESET;
         chal_timeout_ff <= prca_pkg::CHALLENGE_TIMEOUT_RESET;
         cnt_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         hold_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               prca_pkg::CSR_LIVE_TIMEOUT:      live_timeout_ff <= csr_wdata;
               prca_pkg::CSR_CHALLENGE_TIMEOUT: chal_timeout_ff <= csr_wdata[7:0];
            endcase
         end
         if (proc && list_emit) begin
            hold_valid_ff <= 1'b1;
         end else if (load_fin) begin
            hold_valid_ff <= 1'b0;
         end
         if (load_scan || load_fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and scan findings; no reset needed.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff     <= req_action;
         reject_ff  <= req_reject;
         now_ff     <= req_tdata[31:0];
         addr_ff    <= req_tdata[63:32];
         port_ff    <= req_port;
         proto_ff   <= req_proto;
         offered_ff <= req_tdata[109:96];
         rkey_ff    <= req_tdata[123:110];
      end
      if (issue) begin
         s1_idx_ff <= cnt_ff[IDX_W-1:0];
      end
      have_free_ff <= have_free_in;
      hit_ff       <= hit_in;
      cand_ff      <= cand_in;
      res_slot_ff  <= res_slot_in;
      res_kind_ff  <= res_kind_in;
      list_cnt_ff  <= list_cnt_in;
      if (proc && list_emit) begin
         hold_ff <= list_res;
      end
      if (load_scan) begin
         rsp_ff <= hold_ff;
      end else if (load_fin) begin
         rsp_ff <= fin_res;
      end
   end

   // ------------------------------------------------------------------
   // Port packing.
   // ------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.port, rsp_ff.addr, rsp_ff.slot};
   assign rsp_tuser  = {rsp_ff.challenge, rsp_ff.kind};
   assign rsp_tlast  = rsp_ff.last;

`ifndef SYNTHESIS
   // A list beat must never be left behind in the holding register.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == prca_pkg::FSM_IDLE) |-> !hold_valid_ff)
      else $error("holding register still full while idle");

   // The scan never reads the entry that it writes back in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (tbl_rd_en && (st_we || ent_we)) |-> (tbl_rd_idx != tbl_wr_idx))
      else $error("read and write of the same table entry in one cycle");

   // No more list beats than the result limit; the count is set up when a request
   // is accepted, so it is only meaningful during a scan.
   assert property (@(posedge clock) disable iff (reset)
      scanning |-> (list_cnt_ff <= LIST_LIMIT))
      else $error("list beat count beyond limit");

   // The second stage only holds an entry during a scan.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == prca_pkg::FSM_SCAN))
      else $error("stage one valid outside a scan");

   // An accepted request closes the request side until it is finished.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request accepted while another is in progress");
`endif

endmodule

`default_nettype wire

/* rtl/prca_table.sv */
// Status memory and peer data memory with registered reads.
`default_nettype none

module prca_table #(
   parameter int ENTRIES = prca_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [IDX_W-1:0]      rd_idx,
   output prca_pkg::status_type       rd_status_ff,
   output prca_pkg::entry_type        rd_entry_ff,
   input  wire logic [IDX_W-1:0]      wr_idx,
   input  wire logic                  status_we,
   input  wire prca_pkg::status_type  status_wd,
   input  wire logic                  entry_we,
   input  wire prca_pkg::entry_type   entry_wd
);

   prca_pkg::status_type status_mem [ENTRIES];
   prca_pkg::entry_type  entry_mem  [ENTRIES];

   always_ff @(posedge clock) begin
      if (status_we) begin
         status_mem[wr_idx] <= status_wd;
      end
      if (entry_we) begin
         entry_mem[wr_idx] <= entry_wd;
      end
   end

   // Read data holds while the scan is stalled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_status_ff <= status_mem[rd_idx];
         rd_entry_ff  <= entry_mem[rd_idx];
      end
   end

endmodule

`default_nettype wire

/* tb/tb_peer_registry_with_challenge_aging.sv */
// Self-checking testbench for the peer registry with heartbeat, echo and list requests.
module tb_peer_registry_with_challenge_aging;
   import prca_pkg::*;

   // Table size of the block under test. The predictor keeps a table of the same size.
   localparam int ENTRIES     = TABLE_ENTRIES_DEFAULT;
   // Peers that the random traffic draws on, so that the same peers come back often.
   localparam int POOL_SIZE   = 24;
   // Cycles without any accepted beat or register write before the run is abandoned.
   // The longest quiet stretch of a correct run is the deliberate response hold-off
   // plus one scan of the table.
   localparam int STALL_LIMIT = 4000;
   localparam int REPORT_MAX  = 10;

   // One request before it is packed onto the request stream.
   typedef struct {
      action_type  action;
      logic [31:0] now;
      logic [31:0] addr;
      logic [15:0] port;
      logic [15:0] proto;
      logic [13:0] offered;
      logic [13:0] rkey;
   } peer_request;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_LIVE_TIMEOUT;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   peer_registry_with_challenge_aging dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Requests waiting to be offered, and replies that the registry still owes us.
   peer_request queued_requests[$];
   result_type  awaited_replies[$];

   // Shadow copy of the registry: entry state, entry data and both timeouts.
   status_type  shadow_status[ENTRIES];
   logic [31:0] shadow_addr[ENTRIES];
   logic [15:0] shadow_port[ENTRIES];
   logic [15:0] shadow_proto[ENTRIES];
   logic [31:0] shadow_stamp[ENTRIES];
   logic [13:0] shadow_key[ENTRIES];
   logic [15:0] live_timeout      = LIVE_TIMEOUT_RESET;
   logic [7:0]  challenge_timeout = CHALLENGE_TIMEOUT_RESET;

   // Peers used by the random traffic, and the stimulus clock in seconds.
   logic [31:0] pool_addr[POOL_SIZE];
   logic [15:0] pool_port[POOL_SIZE];
   logic [15:0] pool_proto[POOL_SIZE];
   logic [13:0] pool_key[POOL_SIZE];
   logic [31:0] stimulus_now;

   // Idle rates in percent for each side, and the one long response hold-off.
   int send_idle_pct = 23;
   int recv_idle_pct = 51;
   bit pressure_on   = 1'b0;
   bit stall_done    = 1'b0;
   int stall_left    = 0;

   peer_request held_request;
   result_type  seen_reply;
   result_type  wanted_reply;
   int          requests_accepted = 0;
   int          replies_checked   = 0;
   int          listed_entries    = 0;
   int          reply_mismatches  = 0;
   int          quiet_cycles      = 0;

   initial begin
      for (int i = 0; i < ENTRIES; i++) shadow_status[i] = ST_FREE;
   end

   // An entry is stale when its age, taken modulo 2^32, is above the timeout.
   function automatic bit is_expired(input logic [31:0] now, input logic [31:0] stamp,
                                     input logic [15:0] timeout);
      logic [31:0] age;
      age = now - stamp;
      return age > {16'd0, timeout};
   endfunction

   function automatic result_type make_reply(input kind_type kind, input logic challenge,
                                             input int slot, input logic [31:0] addr,
                                             input logic [15:0] port, input logic last);
      result_type r;
      r.kind      = kind;
      r.challenge = challenge;
      r.slot      = slot[5:0];
      r.addr      = addr;
      r.port      = port;
      r.last      = last;
      return r;
   endfunction

   // Applies one accepted request to the shadow registry and queues the replies it owes.
   task automatic predict_registry_replies(input peer_request r);
      bit         have_free;
      bit         matched;
      bit         decided;
      bit         stale;
      int         cand;
      int         hit;
      int         i;
      kind_type   verdict;
      result_type listing[$];
      have_free = 1'b0;
      matched   = 1'b0;
      decided   = 1'b0;
      cand      = 0;
      hit       = 0;
      verdict   = KIND_UNMATCHED;
      case (r.action)
         ACT_HEARTBEAT: begin
            // A heartbeat outside the port window or without a protocol changes nothing.
            if (!(r.port > PORT_MIN_EXCL && r.port < PORT_MAX_EXCL && r.proto != 16'd0)) begin
               awaited_replies.push_back(make_reply(KIND_REJECTED, 1'b0, 0, '0, '0, 1'b1));
            end else begin
               for (i = 0; i < ENTRIES; i++) begin
                  if (shadow_status[i] == ST_FREE) begin
                     if (!have_free) begin
                        have_free = 1'b1;
                        cand      = i;
                     end
                  end else if (shadow_addr[i] == r.addr && shadow_port[i] == r.port) begin
                     shadow_stamp[i] = r.now;
                     if (!matched) begin
                        matched = 1'b1;
                        hit     = i;
                     end
                  end else if (is_expired(r.now, shadow_stamp[i], live_timeout)) begin
                     // Freed during this scan, so it cannot serve as the new slot.
                     shadow_status[i] = ST_FREE;
                  end
               end
               if (matched) begin
                  awaited_replies.push_back(make_reply(KIND_ACK, 1'b0, hit, '0, '0, 1'b1));
               end else if (have_free) begin
                  shadow_status[cand] = ST_PENDING;
                  shadow_addr[cand]   = r.addr;
                  shadow_port[cand]   = r.port;
                  shadow_proto[cand]  = r.proto;
                  shadow_stamp[cand]  = r.now;
                  shadow_key[cand]    = r.offered;
                  awaited_replies.push_back(make_reply(KIND_ACK, 1'b1, cand, '0, '0, 1'b1));
               end else begin
                  awaited_replies.push_back(make_reply(KIND_ACK, 1'b0, 0, '0, '0, 1'b1));
               end
            end
         end
         ACT_ECHO_REPLY: begin
            for (i = 0; i < ENTRIES; i++) begin
               if (shadow_status[i] == ST_PENDING) begin
                  stale = is_expired(r.now, shadow_stamp[i], {8'd0, challenge_timeout});
                  if (stale) shadow_status[i] = ST_FREE;
                  if (!decided && shadow_addr[i] == r.addr && shadow_port[i] == r.port) begin
                     decided = 1'b1;
                     hit     = i;
                     // A late reply fails even when it carries the right key.
                     if (!stale && shadow_key[i] == r.rkey) begin
                        shadow_status[i] = ST_VERIFIED;
                        verdict          = KIND_VERIFIED;
                     end else begin
                        shadow_status[i] = ST_FREE;
                        verdict          = KIND_FAILED;
                     end
                  end
               end
            end
            awaited_replies.push_back(make_reply(verdict, 1'b0, hit, '0, '0, 1'b1));
         end
         ACT_LIST_QUERY: begin
            for (i = 0; i < ENTRIES; i++) begin
               if (shadow_status[i] != ST_FREE &&
                   is_expired(r.now, shadow_stamp[i], live_timeout))
                  shadow_status[i] = ST_FREE;
               if (shadow_status[i] == ST_VERIFIED && listing.size() < MAX_RESULTS)
                  listing.push_back(make_reply(KIND_LIST_ENTRY, 1'b0, i, shadow_addr[i],
                                               shadow_port[i], 1'b0));
            end
            if (listing.size() == 0) begin
               awaited_replies.push_back(make_reply(KIND_EMPTY_LIST, 1'b0, 0, '0, '0, 1'b1));
            end else begin
               listing[listing.size()-1].last = 1'b1;
               foreach (listing[k]) awaited_replies.push_back(listing[k]);
            end
         end
         default: begin
            awaited_replies.push_back(make_reply(KIND_REJECTED, 1'b0, 0, '0, '0, 1'b1));
         end
      endcase
   endtask

   // Request driver. The accepted beat is predicted at the edge that accepts it; the
   // next beat is loaded in the same edge, so tvalid gets one assignment per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_registry_replies(held_request);
            requests_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               held_request = queued_requests.pop_front();
               req_tdata  <= {4'd0, held_request.rkey, held_request.offered,
                              held_request.proto, held_request.port,
                              held_request.addr, held_request.now};
               req_tuser  <= held_request.action;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver. Each accepted beat is checked against the oldest
   // awaited reply. The receiver also owns the long hold-off used to back up the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_reply.kind      = kind_type'(rsp_tuser[2:0]);
            seen_reply.challenge = rsp_tuser[3];
            seen_reply.slot      = rsp_tdata[5:0];
            seen_reply.addr      = rsp_tdata[37:6];
            seen_reply.port      = rsp_tdata[53:38];
            seen_reply.last      = rsp_tlast;
            replies_checked++;
            if (seen_reply.kind == KIND_LIST_ENTRY) listed_entries++;
            if (awaited_replies.size() == 0) begin
               reply_mismatches++;
               if (reply_mismatches <= REPORT_MAX)
                  $display("ERROR: unexpected reply beat kind=%0d slot=%0d addr=%h port=%h",
                           seen_reply.kind, seen_reply.slot, seen_reply.addr,
                           seen_reply.port);
            end else begin
               wanted_reply = awaited_replies.pop_front();
               if (seen_reply.kind !== wanted_reply.kind ||
                   seen_reply.challenge !== wanted_reply.challenge ||
                   seen_reply.slot !== wanted_reply.slot ||
                   seen_reply.addr !== wanted_reply.addr ||
                   seen_reply.port !== wanted_reply.port ||
                   seen_reply.last !== wanted_reply.last) begin
                  reply_mismatches++;
                  if (reply_mismatches <= REPORT_MAX)
                     $display({"ERROR: reply %0d expected kind=%0d chal=%0d slot=%0d ",
                               "addr=%h port=%h last=%0d, got kind=%0d chal=%0d slot=%0d ",
                               "addr=%h port=%h last=%0d"},
                              replies_checked, wanted_reply.kind, wanted_reply.challenge,
                              wanted_reply.slot, wanted_reply.addr, wanted_reply.port,
                              wanted_reply.last, seen_reply.kind, seen_reply.challenge,
                              seen_reply.slot, seen_reply.addr, seen_reply.port,
                              seen_reply.last);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (pressure_on && !stall_done) begin
            stall_left <= 600;
            stall_done <= 1'b1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: any accepted beat or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_request(input action_type action, input logic [31:0] now,
                               input logic [31:0] addr, input logic [15:0] port,
                               input logic [15:0] proto, input logic [13:0] offered,
                               input logic [13:0] rkey);
      peer_request r;
      r.action  = action;
      r.now     = now;
      r.addr    = addr;
      r.port    = port;
      r.proto   = proto;
      r.offered = offered;
      r.rkey    = rkey;
      queued_requests.push_back(r);
   endtask

   // Register writes happen only while the block is idle, so the shadow copy can follow
   // at once.
   task automatic write_timeout(input logic [CSR_INDEX_W-1:0] index,
                                input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (index == CSR_LIVE_TIMEOUT) live_timeout = value;
      else challenge_timeout = value[7:0];
   endtask

   task automatic wait_until_drained();
      while (queued_requests.size() != 0 || req_tvalid || awaited_replies.size() != 0)
         @(posedge clock);
   endtask

   // Moves the stimulus clock: mostly by up to two seconds, sometimes far enough that
   // live entries go stale, and now and then by a random amount that may wrap.
   task automatic step_clock();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70)      stimulus_now += $urandom_range(2);
      else if (roll < 88) stimulus_now += $urandom_range(30, 3);
      else if (roll < 97) stimulus_now += live_timeout + $urandom_range(40);
      else                stimulus_now += $urandom;
   endtask

   // Random traffic. Most of it is register-then-answer sequences from known peers,
   // so that entries actually reach the verified state; the rest is list queries,
   // stray echo replies and requests with arbitrary fields.
   task automatic queue_random_traffic(input int count);
      int          made;
      int          roll;
      int          pick;
      logic [15:0] port;
      logic [13:0] rkey;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(99);
         pick = $urandom_range(POOL_SIZE - 1);
         step_clock();
         if (roll < 55) begin
            push_request(ACT_HEARTBEAT, stimulus_now, pool_addr[pick], pool_port[pick],
                         pool_proto[pick], pool_key[pick], 14'($urandom_range(16383)));
            made++;
            if ($urandom_range(3) == 0) begin
               stimulus_now += $urandom_range(2);
               push_request(ACT_HEARTBEAT, stimulus_now, pool_addr[pick], pool_port[pick],
                            16'($urandom_range(65535, 1)), 14'($urandom_range(9998, 1000)),
                            '0);
               made++;
            end
            // The answer usually comes inside the challenge window, sometimes just after.
            stimulus_now += $urandom_range(challenge_timeout + 1);
            rkey = ($urandom_range(99) < 85) ? pool_key[pick] : 14'($urandom_range(16383));
            push_request(ACT_ECHO_REPLY, stimulus_now, pool_addr[pick], pool_port[pick],
                         16'($urandom_range(65535)), 14'($urandom_range(9998, 1000)), rkey);
            made++;
         end else if (roll < 70) begin
            push_request(ACT_LIST_QUERY, stimulus_now, $urandom, 16'($urandom_range(65535)),
                         16'($urandom_range(65535)), 14'($urandom_range(9998, 1000)),
                         14'($urandom_range(16383)));
            made++;
         end else if (roll < 82) begin
            port = ($urandom_range(1) == 0) ? pool_port[pick] : 16'($urandom_range(65535));
            push_request(ACT_ECHO_REPLY, stimulus_now, pool_addr[pick], port,
                         16'($urandom_range(65535)), 14'($urandom_range(9998, 1000)),
                         14'($urandom_range(16383)));
            made++;
         end else begin
            case ($urandom_range(4))
               0:       port = 16'd0;
               1:       port = PORT_MIN_EXCL;
               2:       port = PORT_MAX_EXCL;
               default: port = 16'($urandom_range(65535));
            endcase
            push_request(action_type'(2'($urandom_range(3))), stimulus_now, $urandom, port,
                         ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(65535)),
                         14'($urandom_range(9998, 1000)), 14'($urandom_range(16383)));
            made++;
         end
      end
   endtask

   // Stimulus and sequencing of the run.
   initial begin
      logic [31:0] t;
      logic [31:0] fill_addr[ENTRIES + 1];
      logic [15:0] fill_port[ENTRIES + 1];
      logic [13:0] fill_key[ENTRIES + 1];

      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_addr[i]  = $urandom;
         pool_port[i]  = 16'($urandom_range(65534, 1025));
         pool_proto[i] = 16'($urandom_range(65535, 1));
         pool_key[i]   = 14'($urandom_range(9998, 1000));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset timeouts (live 300 s, challenge 2 s).
      send_idle_pct = 23;
      recv_idle_pct = 51;
      t = 32'd5000;
      push_request(ACT_LIST_QUERY, t, '0, '0, '0, 14'd1000, '0);          // empty table
      // The port window is open at both ends, and protocol zero is refused.
      push_request(ACT_HEARTBEAT, t, 32'h0A000001, 16'd1024, 16'd6, 14'd1000, '0);
      push_request(ACT_HEARTBEAT, t, 32'h0A000001, 16'd65535, 16'd6, 14'd1000, '0);
      push_request(ACT_HEARTBEAT, t, 32'h0A000001, 16'd0, 16'd6, 14'd1000, '0);
      push_request(ACT_HEARTBEAT, t, 32'h0A000001, 16'd2000, 16'd0, 14'd1000, '0);
      push_request(ACT_UNUSED, t, '1, '1, '1, 14'd9998, '1);
      // New peer at the lowest legal port, then a refresh, then a wrong key.
      push_request(ACT_HEARTBEAT, t, 32'hFFFF_FFFF, 16'd1025, 16'hFFFF, 14'd9998, '0);
      push_request(ACT_HEARTBEAT, t + 1, 32'hFFFF_FFFF, 16'd1025, 16'd17, 14'd1234, '0);
      push_request(ACT_ECHO_REPLY, t + 1, 32'hFFFF_FFFF, 16'd1025, '0, 14'd1000, 14'h3FFF);
      // Right key answered exactly at the challenge timeout still verifies.
      push_request(ACT_HEARTBEAT, t + 2, 32'h0000_0000, 16'd65534, 16'd1, 14'd1000, '0);
      push_request(ACT_ECHO_REPLY, t + 4, 32'h0000_0000, 16'd65534, '0, 14'd1000, 14'd1000);
      // Right key one second too late fails and leaves the entry freed.
      push_request(ACT_HEARTBEAT, t + 4, 32'hC0A8_0001, 16'd40000, 16'd17, 14'd5555, '0);
      push_request(ACT_ECHO_REPLY, t + 7, 32'hC0A8_0001, 16'd40000, '0, 14'd1000, 14'd5555);
      push_request(ACT_ECHO_REPLY, t + 7, 32'h1234_5678, 16'd3000, '0, 14'd1000, 14'd77);
      // Same address but another port does not match.
      push_request(ACT_HEARTBEAT, t + 8, 32'h0A0A_0A0A, 16'd5000, 16'd6, 14'd4321, '0);
      push_request(ACT_ECHO_REPLY, t + 8, 32'h0A0A_0A0A, 16'd5001, '0, 14'd1000, 14'd4321);
      push_request(ACT_LIST_QUERY, t + 9, '0, '0, '0, 14'd1000, '0);
      // Past the live timeout the verified entry ages out of the list.
      push_request(ACT_LIST_QUERY, t + 305, '0, '0, '0, 14'd1000, '0);
      // Ages are taken modulo 2^32, across the wrap of the seconds counter.
      push_request(ACT_HEARTBEAT, 32'hFFFF_FFFF, 32'h0102_0304, 16'd8080, 16'd6, 14'd8191, '0);
      push_request(ACT_ECHO_REPLY, 32'd1, 32'h0102_0304, 16'd8080, '0, 14'd1000, 14'd8191);
      push_request(ACT_LIST_QUERY, 32'd1, '0, '0, '0, 14'd1000, '0);
      wait_until_drained();

      // Short timeouts of one second: entries expire almost at once.
      write_timeout(CSR_LIVE_TIMEOUT, 16'd1);
      write_timeout(CSR_CHALLENGE_TIMEOUT, 16'd1);
      stimulus_now = $urandom;
      queue_random_traffic(79);
      // A late list query empties the table for the fill that follows.
      stimulus_now += 32'd100000;
      push_request(ACT_LIST_QUERY, stimulus_now, '0, '0, '0, 14'd1000, '0);
      wait_until_drained();

      // Longest timeouts: fill every entry, verify all of them and list a full table.
      send_idle_pct = 51;
      recv_idle_pct = 23;
      write_timeout(CSR_LIVE_TIMEOUT, 16'd65535);
      write_timeout(CSR_CHALLENGE_TIMEOUT, 16'd255);
      for (int i = 0; i <= ENTRIES; i++) begin
         fill_addr[i] = ($urandom & ~32'h3F) | i;
         fill_port[i] = 16'($urandom_range(65534, 1025));
         fill_key[i]  = 14'($urandom_range(9998, 1000));
      end
      for (int i = 0; i < ENTRIES; i++) begin
         stimulus_now += $urandom_range(1);
         push_request(ACT_HEARTBEAT, stimulus_now, fill_addr[i], fill_port[i],
                      16'($urandom_range(65535, 1)), fill_key[i], '0);
         stimulus_now += $urandom_range(3);
         push_request(ACT_ECHO_REPLY, stimulus_now, fill_addr[i], fill_port[i], '0,
                      14'd1000, fill_key[i]);
      end
      push_request(ACT_LIST_QUERY, stimulus_now, '0, '0, '0, 14'd1000, '0);
      // With no free entry a new peer still gets an ack, without a challenge.
      push_request(ACT_HEARTBEAT, stimulus_now, fill_addr[ENTRIES], fill_port[ENTRIES],
                   16'd6, fill_key[ENTRIES], '0);
      push_request(ACT_HEARTBEAT, stimulus_now + 1, fill_addr[37], fill_port[37], 16'd6,
                   fill_key[37], '0);
      push_request(ACT_ECHO_REPLY, stimulus_now + 1, fill_addr[ENTRIES], fill_port[ENTRIES],
                   '0, 14'd1000, fill_key[ENTRIES]);
      push_request(ACT_LIST_QUERY, stimulus_now + 2, '0, '0, '0, 14'd1000, '0);
      wait_until_drained();

      // Middle timeouts, no random idling, and one long response hold-off at the start
      // while requests keep coming, so the block backs up into its request side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_timeout(CSR_LIVE_TIMEOUT, 16'd20);
      write_timeout(CSR_CHALLENGE_TIMEOUT, 16'd4);
      pressure_on = 1'b1;
      stimulus_now += 32'd70000;
      push_request(ACT_LIST_QUERY, stimulus_now, '0, '0, '0, 14'd1000, '0);
      queue_random_traffic(75);
      wait_until_drained();

      // Leave room for any reply that the block should not have produced.
      repeat (ENTRIES + 16) @(posedge clock);
      $display("summary: %0d requests accepted, %0d reply beats checked, %0d listed entries",
               requests_accepted, replies_checked, listed_entries);
      $display("summary: four timeout settings including both extremes, full table reached");
      if (reply_mismatches == 0 && awaited_replies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("ERROR: %0d mismatching beats, %0d replies never arrived",
                  reply_mismatches, awaited_replies.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* peer_registry_with_challenge_aging.f */
rtl/prca_pkg.sv
rtl/prca_table.sv
rtl/peer_registry_with_challenge_aging.sv
tb/tb_peer_registry_with_challenge_aging.sv
